// ----- hdl/load_thermal_governor_select_assert.svh -----
// Assertion macros for the load and thermal governor selector checks.
`ifndef LOAD_THERMAL_GOVERNOR_SELECT_ASSERT_SVH
`define LOAD_THERMAL_GOVERNOR_SELECT_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define LTG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define LTG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ltg_pkg.sv -----
// Shared types and constants for the load and thermal governor selector.
package ltg_pkg;

    localparam int CNT_W  = 63;
    localparam int TOT_W  = 64;
    localparam int MUL_BW = 10;
    localparam int AW     = TOT_W + MUL_BW;

    localparam logic [1:0] MODE_UNMANAGED   = 2'd0;
    localparam logic [1:0] MODE_POWERSAVE   = 2'd1;
    localparam logic [1:0] MODE_PERFORMANCE = 2'd2;

    localparam logic [1:0] REG_POLL = 2'd0;
    localparam logic [1:0] REG_HIGH = 2'd1;
    localparam logic [1:0] REG_LOW  = 2'd2;
    localparam logic [1:0] REG_TEMP = 2'd3;

    localparam logic [11:0] POLL_RST = 12'd2;
    localparam logic [9:0]  HIGH_RST = 10'd600;
    localparam logic [9:0]  LOW_RST  = 10'd250;
    localparam logic [7:0]  TEMP_RST = 8'd85;

    localparam logic [MUL_BW-1:0] LOAD_SCALE = 10'd1000;
    localparam logic [9:0]        SHARE_MAX  = 10'd1000;

    typedef struct packed {
        logic [AW-1:0]     add_a;
        logic [AW-1:0]     add_b;
        logic              add_sub;
        logic [TOT_W-1:0]  mul_a;
        logic [MUL_BW-1:0] mul_b;
    } t_alu_req;

    typedef struct packed {
        logic [AW:0]   sum;
        logic [AW-1:0] prod;
    } t_alu_rsp;

endpackage

// ----- hdl/ltg_alu.sv -----
// Shared adder/subtractor and registered 64x10 multiplier.
module ltg_alu import ltg_pkg::*; (
    input  logic     i_clk,
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [AW-1:0] r_prod;
    logic [AW-1:0] n_prod;
    logic [AW-1:0] b_eff;

    assign b_eff = i_req.add_sub ? ~i_req.add_b : i_req.add_b;

    // carry out of a subtract is set when add_a >= add_b
    assign o_rsp.sum = {1'b0, i_req.add_a} + {1'b0, b_eff} + {{AW{1'b0}}, i_req.add_sub};

    assign n_prod = {{MUL_BW{1'b0}}, i_req.mul_a} * {{TOT_W{1'b0}}, i_req.mul_b};

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_rsp.prod = r_prod;

endmodule

// ----- hdl/load_thermal_governor_select.sv -----
// Top level of the load and thermal governor selector with time accounting.
// From accept to o_out_valid: a priming poll sums the fields; a decided poll also forms the
// deltas and, when the total delta is positive, the threshold products; a report sums the
// counters and, unless all are zero, divides for the share; output stalls add to each. Requests
// go one at a time; o_in_ready rises with o_out_valid.
// Reset (synchronous, active low) clears mode, counters and priming, restores registers.
module load_thermal_governor_select import ltg_pkg::*; #(
    parameter int TIME_BITS = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_action,
    input  logic [CNT_W-1:0]     i_user_time,
    input  logic [CNT_W-1:0]     i_nice_time,
    input  logic [CNT_W-1:0]     i_system_time,
    input  logic [CNT_W-1:0]     i_idle_time,
    input  logic [CNT_W-1:0]     i_iowait_time,
    input  logic [CNT_W-1:0]     i_irq_time,
    input  logic [CNT_W-1:0]     i_softirq_time,
    input  logic signed [8:0]    i_hottest_temp_c,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_mode,
    output logic                 o_mode_changed,
    output logic [TIME_BITS-1:0] o_secs_powersave,
    output logic [TIME_BITS-1:0] o_secs_performance,
    output logic [TIME_BITS-1:0] o_secs_unmanaged,
    output logic [9:0]           o_powersave_share,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_SUM   = 5'd1;
    localparam logic [4:0] ST_PRIME = 5'd2;
    localparam logic [4:0] ST_TOT   = 5'd3;
    localparam logic [4:0] ST_LAST  = 5'd4;
    localparam logic [4:0] ST_DT    = 5'd5;
    localparam logic [4:0] ST_DI    = 5'd6;
    localparam logic [4:0] ST_ACT   = 5'd7;
    localparam logic [4:0] ST_M1    = 5'd8;
    localparam logic [4:0] ST_M2    = 5'd9;
    localparam logic [4:0] ST_M3    = 5'd10;
    localparam logic [4:0] ST_M4    = 5'd11;
    localparam logic [4:0] ST_UPD   = 5'd12;
    localparam logic [4:0] ST_R1    = 5'd13;
    localparam logic [4:0] ST_R2    = 5'd14;
    localparam logic [4:0] ST_R3    = 5'd15;
    localparam logic [4:0] ST_RQ    = 5'd16;
    localparam logic [4:0] ST_RC    = 5'd17;
    localparam logic [4:0] ST_OUT   = 5'd18;

    localparam logic [2:0] FLD_IDLE_LAST = 3'd1;
    localparam logic [2:0] FLD_ACT_FIRST = 3'd2;
    localparam logic [2:0] FLD_LAST      = 3'd6;
    localparam logic [3:0] BIT_TOP       = 4'd9;

    logic [4:0]           r_state;
    logic [11:0]          r_poll;
    logic [9:0]           r_high;
    logic [9:0]           r_low;
    logic [7:0]           r_temp;
    logic [CNT_W-1:0]     r_fld [7];
    logic [8:0]           r_temp_in;
    logic [2:0]           r_cnt;
    logic [TOT_W-1:0]     r_acc;
    logic [TOT_W-1:0]     r_idle;
    logic [TOT_W-1:0]     r_active;
    logic [TOT_W-1:0]     r_last_idle;
    logic [TOT_W-1:0]     r_last_active;
    logic [TOT_W-1:0]     r_cur;
    logic [TOT_W-1:0]     r_lsum;
    logic [TOT_W-1:0]     r_dt;
    logic [TOT_W-1:0]     r_di;
    logic [TOT_W-1:0]     r_act;
    logic [AW-1:0]        r_p;
    logic                 r_high_hit;
    logic                 r_low_hit;
    logic                 r_primed;
    logic [1:0]           r_mode;
    logic                 r_changed;
    logic [TIME_BITS-1:0] r_ps;
    logic [TIME_BITS-1:0] r_pf;
    logic [TIME_BITS-1:0] r_um;
    logic [TOT_W-1:0]     r_tot;
    logic [AW-1:0]        r_rhs;
    logic [9:0]           r_q;
    logic [3:0]           r_bit;
    logic [9:0]           r_share;
    logic                 r_out_valid;
    logic [1:0]           r_o_mode;
    logic                 r_o_changed;
    logic [TIME_BITS-1:0] r_o_ps;
    logic [TIME_BITS-1:0] r_o_pf;
    logic [TIME_BITS-1:0] r_o_um;
    logic [9:0]           r_o_share;

    t_alu_req             alu_req;
    t_alu_rsp             alu_rsp;
    logic                 cfg_wr;
    logic                 accept;
    logic                 out_free;
    logic                 hot;
    logic                 dt_ok;
    logic [1:0]           n_mode;
    logic [TIME_BITS-1:0] sec_cur;
    logic [TIME_BITS-1:0] sec_sat;
    logic [TOT_W-1:0]     tot_sat;
    logic [9:0]           bit_mask;
    logic [9:0]           n_q;

    ltg_alu u_alu (
        .i_clk (i_clk),
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    assign pready     = 1'b1;
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        case (paddr[3:2])
            REG_POLL: prdata = {20'd0, r_poll};
            REG_HIGH: prdata = {22'd0, r_high};
            REG_LOW:  prdata = {22'd0, r_low};
            REG_TEMP: prdata = {24'd0, r_temp};
            default:  prdata = '0;
        endcase
    end

    assign hot      = !r_temp_in[8] && (r_temp_in[7:0] > r_temp);
    assign dt_ok    = (r_dt != '0) && !r_dt[TOT_W-1];
    assign bit_mask = 10'd1 << r_bit;
    assign n_q      = alu_rsp.sum[AW] ? (r_q | bit_mask) : r_q;
    assign sec_sat  = (|alu_rsp.sum[AW:TIME_BITS]) ? '1 : alu_rsp.sum[TIME_BITS-1:0];
    assign tot_sat  = (|alu_rsp.sum[AW:TOT_W]) ? '1 : alu_rsp.sum[TOT_W-1:0];

    always_comb begin
        if (hot) begin
            n_mode = MODE_POWERSAVE;
        end else if (r_high_hit) begin
            n_mode = MODE_PERFORMANCE;
        end else if (r_low_hit) begin
            n_mode = MODE_POWERSAVE;
        end else begin
            n_mode = r_mode;
        end
    end

    always_comb begin
        case (n_mode)
            MODE_POWERSAVE:   sec_cur = r_ps;
            MODE_PERFORMANCE: sec_cur = r_pf;
            default:          sec_cur = r_um;
        endcase
    end

    always_comb begin
        alu_req = '0;
        case (r_state)
            ST_SUM: begin
                alu_req.add_a = (r_cnt == '0 || r_cnt == FLD_ACT_FIRST) ? '0 : AW'(r_acc);
                alu_req.add_b = AW'(r_fld[r_cnt]);
            end
            ST_TOT: begin
                alu_req.add_a = AW'(r_idle);
                alu_req.add_b = AW'(r_active);
            end
            ST_LAST: begin
                alu_req.add_a = AW'(r_last_idle);
                alu_req.add_b = AW'(r_last_active);
            end
            ST_DT: begin
                alu_req.add_a   = AW'(r_cur);
                alu_req.add_b   = AW'(r_lsum);
                alu_req.add_sub = 1'b1;
            end
            ST_DI: begin
                alu_req.add_a   = AW'(r_idle);
                alu_req.add_b   = AW'(r_last_idle);
                alu_req.add_sub = 1'b1;
            end
            ST_ACT: begin
                alu_req.add_a   = AW'(r_dt);
                alu_req.add_b   = AW'(r_di);
                alu_req.add_sub = 1'b1;
            end
            ST_M1: begin
                alu_req.mul_a = r_act;
                alu_req.mul_b = LOAD_SCALE;
            end
            ST_M2: begin
                alu_req.mul_a = r_dt;
                alu_req.mul_b = r_high;
            end
            ST_M3: begin
                alu_req.mul_a   = r_dt;
                alu_req.mul_b   = r_low;
                alu_req.add_a   = alu_rsp.prod;
                alu_req.add_b   = r_p;
                alu_req.add_sub = 1'b1;
            end
            ST_M4: begin
                alu_req.add_a   = r_p;
                alu_req.add_b   = alu_rsp.prod;
                alu_req.add_sub = 1'b1;
            end
            ST_UPD: begin
                alu_req.add_a = AW'(sec_cur);
                alu_req.add_b = AW'(r_poll);
            end
            ST_R1: begin
                alu_req.add_a = AW'(r_ps);
                alu_req.add_b = AW'(r_pf);
            end
            ST_R2: begin
                alu_req.add_a = AW'(r_tot);
                alu_req.add_b = AW'(r_um);
                alu_req.mul_a = TOT_W'(r_ps);
                alu_req.mul_b = LOAD_SCALE;
            end
            ST_R3: begin
                alu_req.add_a = alu_rsp.prod;
                alu_req.add_b = AW'(r_tot >> 1);
            end
            ST_RQ: begin
                alu_req.mul_a = r_tot;
                alu_req.mul_b = r_q | bit_mask;
            end
            ST_RC: begin
                alu_req.add_a   = r_rhs;
                alu_req.add_b   = alu_rsp.prod;
                alu_req.add_sub = 1'b1;
            end
            default: begin
                alu_req = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fld[0]    <= i_idle_time;
            r_fld[1]    <= i_iowait_time;
            r_fld[2]    <= i_user_time;
            r_fld[3]    <= i_nice_time;
            r_fld[4]    <= i_system_time;
            r_fld[5]    <= i_irq_time;
            r_fld[6]    <= i_softirq_time;
            r_temp_in   <= i_hottest_temp_c;
        end
        case (r_state)
            ST_SUM: begin
                r_acc <= alu_rsp.sum[TOT_W-1:0];
                if (r_cnt == FLD_IDLE_LAST) begin
                    r_idle <= alu_rsp.sum[TOT_W-1:0];
                end
                if (r_cnt == FLD_LAST) begin
                    r_active <= alu_rsp.sum[TOT_W-1:0];
                end
            end
            ST_TOT:  r_cur  <= alu_rsp.sum[TOT_W-1:0];
            ST_LAST: r_lsum <= alu_rsp.sum[TOT_W-1:0];
            ST_DT:   r_dt   <= alu_rsp.sum[TOT_W-1:0];
            ST_DI:   r_di   <= alu_rsp.sum[TOT_W-1:0];
            ST_ACT: begin
                if (r_di[TOT_W-1]) begin
                    r_act <= r_dt;
                end else if (!alu_rsp.sum[AW]) begin
                    r_act <= '0;
                end else begin
                    r_act <= alu_rsp.sum[TOT_W-1:0];
                end
            end
            ST_M2: r_p <= alu_rsp.prod;
            ST_R3: r_rhs <= alu_rsp.sum[AW-1:0];
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_poll        <= POLL_RST;
            r_high        <= HIGH_RST;
            r_low         <= LOW_RST;
            r_temp        <= TEMP_RST;
            r_cnt         <= '0;
            r_primed      <= 1'b0;
            r_mode        <= MODE_UNMANAGED;
            r_changed     <= 1'b0;
            r_high_hit    <= 1'b0;
            r_low_hit     <= 1'b0;
            r_last_idle   <= '0;
            r_last_active <= '0;
            r_ps          <= '0;
            r_pf          <= '0;
            r_um          <= '0;
            r_tot         <= '0;
            r_q           <= '0;
            r_bit         <= '0;
            r_share       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_POLL: r_poll <= pwdata[11:0];
                    REG_HIGH: r_high <= pwdata[9:0];
                    REG_LOW:  r_low  <= pwdata[9:0];
                    REG_TEMP: r_temp <= pwdata[7:0];
                    default: begin
                    end
                endcase
            end
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_cnt     <= '0;
                        r_changed <= 1'b0;
                        r_share   <= '0;
                        r_state   <= i_action ? ST_R1 : ST_SUM;
                    end
                end
                ST_SUM: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == FLD_LAST) begin
                        r_state <= r_primed ? ST_TOT : ST_PRIME;
                    end
                end
                ST_PRIME: begin
                    r_primed      <= 1'b1;
                    r_last_idle   <= r_idle;
                    r_last_active <= r_active;
                    r_state       <= ST_OUT;
                end
                ST_TOT:  r_state <= ST_LAST;
                ST_LAST: r_state <= ST_DT;
                ST_DT:   r_state <= ST_DI;
                ST_DI:   r_state <= ST_ACT;
                ST_ACT: begin
                    if (dt_ok) begin
                        r_state <= ST_M1;
                    end else begin
                        r_high_hit <= 1'b0;
                        r_low_hit  <= (r_low != '0);
                        r_state    <= ST_UPD;
                    end
                end
                ST_M1: r_state <= ST_M2;
                ST_M2: r_state <= ST_M3;
                ST_M3: begin
                    r_high_hit <= !alu_rsp.sum[AW];
                    r_state    <= ST_M4;
                end
                ST_M4: begin
                    r_low_hit <= !alu_rsp.sum[AW];
                    r_state   <= ST_UPD;
                end
                ST_UPD: begin
                    r_changed     <= (n_mode != r_mode);
                    r_mode        <= n_mode;
                    r_last_idle   <= r_idle;
                    r_last_active <= r_active;
                    case (n_mode)
                        MODE_POWERSAVE:   r_ps <= sec_sat;
                        MODE_PERFORMANCE: r_pf <= sec_sat;
                        default:          r_um <= sec_sat;
                    endcase
                    r_state <= ST_OUT;
                end
                ST_R1: begin
                    r_tot   <= tot_sat;
                    r_state <= ST_R2;
                end
                ST_R2: begin
                    r_tot   <= tot_sat;
                    r_state <= ST_R3;
                end
                ST_R3: begin
                    r_q   <= '0;
                    r_bit <= BIT_TOP;
                    if (r_tot == '0) begin
                        r_share <= '0;
                        r_state <= ST_OUT;
                    end else begin
                        r_state <= ST_RQ;
                    end
                end
                ST_RQ: r_state <= ST_RC;
                ST_RC: begin
                    r_q <= n_q;
                    if (r_bit == '0) begin
                        r_share <= (n_q > SHARE_MAX) ? SHARE_MAX : n_q;
                        r_state <= ST_OUT;
                    end else begin
                        r_bit   <= r_bit - 4'd1;
                        r_state <= ST_RQ;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            r_o_mode    <= r_mode;
            r_o_changed <= r_changed;
            r_o_ps      <= r_ps;
            r_o_pf      <= r_pf;
            r_o_um      <= r_um;
            r_o_share   <= r_share;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_mode             = r_o_mode;
    assign o_mode_changed     = r_o_changed;
    assign o_secs_powersave   = r_o_ps;
    assign o_secs_performance = r_o_pf;
    assign o_secs_unmanaged   = r_o_um;
    assign o_powersave_share  = r_o_share;

endmodule

// ----- hdl/ltg_chk.sv -----
// Port-level checker for the load and thermal governor selector, bound to the top level.
module ltg_chk import ltg_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [1:0] o_mode,
    input logic       o_mode_changed,
    input logic [9:0] o_powersave_share
);

`include "load_thermal_governor_select_assert.svh"

    `LTG_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready, "ready after accept")
    `LTG_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_mode) && $stable(o_powersave_share), "stalled result changed")
    `LTG_ASSERT_NOW(a_share_range, o_out_valid, o_powersave_share <= SHARE_MAX, "share above full scale")
    `LTG_ASSERT_NOW(a_change_no_share, o_out_valid && o_mode_changed, o_powersave_share == '0, "share on a mode change")

endmodule

bind load_thermal_governor_select ltg_chk u_ltg_chk (.*);
